// ===== design/cpml_point_update_macros.svh =====
// Assertion helpers used by cpml_back.sv.
`ifndef CPML_POINT_UPDATE_MACROS_SVH
`define CPML_POINT_UPDATE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CPML_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cpml assertion failed");

// The consequent holds in the cycle after the antecedent.
`define CPML_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cpml assertion failed");

`endif

// ===== design/cpml_pkg.sv =====
package cpml_pkg;

    localparam int DATA_W          = 32;
    localparam int SLOT_W          = 12;
    localparam int DIFF_W          = 33;
    localparam int DEF_POINT_SLOTS = 4096;
    localparam int PADDR_W         = 2;

    localparam logic [PADDR_W-1:0] ADDR_ISP  = 2'd0;
    localparam logic [31:0]        ISP_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [SLOT_W-1:0]        slot;
        logic signed [DIFF_W-1:0] diff_a;
        logic signed [DIFF_W-1:0] diff_b;
        logic signed [31:0]       accum;
        logic signed [31:0]       decay_a;
        logic signed [31:0]       gain_a;
        logic signed [31:0]       kinv_a;
        logic signed [31:0]       decay_b;
        logic signed [31:0]       gain_b;
        logic signed [31:0]       kinv_b;
    } t_item;

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

// ===== design/cpml_point_update.sv =====
// Convolutional PML point update.
// Input words enter by push/full: one word per boundary point, with its slot, four
// neighbour field samples, the accumulator value and six coefficients. Result words
// leave by empty/pop: the slot, the updated saturated accumulator and a clip flag.
// The reciprocal grid spacing is set over the APB port at byte address 0, only while
// no word is in flight: a rule for the user, not enforced by the block. A new word
// is taken every cycle while full is low; each result passes a two-entry input
// queue, a five-stage arithmetic pipe and a two-entry result queue. Words for the
// same slot may follow each other on consecutive cycles; newer terms are forwarded
// from the write stage. After reset the stored convolution terms are cleared by one
// pass over all POINT_SLOTS entries, during which full stays high; configuration
// writes are still taken. When the receiver does not pop, the result queue fills,
// the pipe holds, the input queue fills and full rises. Nothing is dropped.
module cpml_point_update
    import cpml_pkg::*;
#(
    parameter int POINT_SLOTS = DEF_POINT_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [31:0]        i_field_fwd_a,
    input  logic [31:0]        i_field_back_a,
    input  logic [31:0]        i_field_fwd_b,
    input  logic [31:0]        i_field_back_b,
    input  logic [31:0]        i_accum_in,
    input  logic [31:0]        i_decay_a,
    input  logic [31:0]        i_gain_a,
    input  logic [31:0]        i_stretch_inv_a,
    input  logic [31:0]        i_decay_b,
    input  logic [31:0]        i_gain_b,
    input  logic [31:0]        i_stretch_inv_b,
    output logic               empty,
    input  logic               pop,
    output logic [SLOT_W-1:0]  o_out_slot,
    output logic [31:0]        o_accum_out,
    output logic               o_saturated
);

    localparam int AW = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;

    logic [31:0]   r_isp;
    logic          w_hd_v;
    t_item         w_hd_item;
    logic [AW-1:0] w_hd_idx;
    logic          w_hd_pop;
    logic          w_clearing;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ISP) ? r_isp : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isp <= ISP_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_ISP)) begin
            r_isp <= pwdata;
        end
    end

    cpml_front #(
        .POINT_SLOTS (POINT_SLOTS),
        .AW          (AW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_slot          (i_slot),
        .i_field_fwd_a   (i_field_fwd_a),
        .i_field_back_a  (i_field_back_a),
        .i_field_fwd_b   (i_field_fwd_b),
        .i_field_back_b  (i_field_back_b),
        .i_accum_in      (i_accum_in),
        .i_decay_a       (i_decay_a),
        .i_gain_a        (i_gain_a),
        .i_stretch_inv_a (i_stretch_inv_a),
        .i_decay_b       (i_decay_b),
        .i_gain_b        (i_gain_b),
        .i_stretch_inv_b (i_stretch_inv_b),
        .i_clearing      (w_clearing),
        .i_hd_pop        (w_hd_pop),
        .o_hd_v          (w_hd_v),
        .o_hd_item       (w_hd_item),
        .o_hd_idx        (w_hd_idx)
    );

    cpml_back #(
        .POINT_SLOTS (POINT_SLOTS),
        .AW          (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_isp       (r_isp),
        .i_hd_v      (w_hd_v),
        .i_hd_item   (w_hd_item),
        .i_hd_idx    (w_hd_idx),
        .o_hd_pop    (w_hd_pop),
        .o_clearing  (w_clearing),
        .empty       (empty),
        .pop         (pop),
        .o_out_slot  (o_out_slot),
        .o_accum_out (o_accum_out),
        .o_saturated (o_saturated)
    );

endmodule

// ===== design/cpml_front.sv =====
module cpml_front
    import cpml_pkg::*;
#(
    parameter int POINT_SLOTS = DEF_POINT_SLOTS,
    parameter int AW          = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [31:0]       i_field_fwd_a,
    input  logic [31:0]       i_field_back_a,
    input  logic [31:0]       i_field_fwd_b,
    input  logic [31:0]       i_field_back_b,
    input  logic [31:0]       i_accum_in,
    input  logic [31:0]       i_decay_a,
    input  logic [31:0]       i_gain_a,
    input  logic [31:0]       i_stretch_inv_a,
    input  logic [31:0]       i_decay_b,
    input  logic [31:0]       i_gain_b,
    input  logic [31:0]       i_stretch_inv_b,
    input  logic              i_clearing,
    input  logic              i_hd_pop,
    output logic              o_hd_v,
    output t_item             o_hd_item,
    output logic [AW-1:0]     o_hd_idx
);

    logic [AW-1:0] w_idx;
    t_item         w_item;
    logic          w_wr;
    t_item         r_q_item [2];
    logic [AW-1:0] r_q_idx  [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;

    // Below 4096 slots, the slot folds by a reciprocal multiply.
    generate
        if (POINT_SLOTS >= (1 << SLOT_W)) begin : g_direct
            assign w_idx = AW'(i_slot);
        end else begin : g_fold
            localparam int LOG = $clog2(POINT_SLOTS);
            localparam int K   = SLOT_W + LOG;
            localparam logic [12:0] MUL = 13'(((1 << K) + POINT_SLOTS - 1) / POINT_SLOTS);
            logic [24:0]       w_prod;
            logic [SLOT_W-1:0] w_q;
            logic [SLOT_W-1:0] w_r;
            assign w_prod = 25'(i_slot) * 25'(MUL);
            assign w_q    = SLOT_W'(w_prod >> K);
            assign w_r    = i_slot - SLOT_W'(w_q * SLOT_W'(POINT_SLOTS));
            assign w_idx  = AW'(w_r);
        end
    endgenerate

    always_comb begin
        w_item.slot    = i_slot;
        w_item.diff_a  = {i_field_fwd_a[31], i_field_fwd_a}
                       - {i_field_back_a[31], i_field_back_a};
        w_item.diff_b  = {i_field_fwd_b[31], i_field_fwd_b}
                       - {i_field_back_b[31], i_field_back_b};
        w_item.accum   = i_accum_in;
        w_item.decay_a = i_decay_a;
        w_item.gain_a  = i_gain_a;
        w_item.kinv_a  = i_stretch_inv_a;
        w_item.decay_b = i_decay_b;
        w_item.gain_b  = i_gain_b;
        w_item.kinv_b  = i_stretch_inv_b;
    end

    assign full      = (r_cnt == 2'd2) || i_clearing;
    assign w_wr      = push && !full;
    assign o_hd_v    = (r_cnt != 2'd0);
    assign o_hd_item = r_q_item[r_rp];
    assign o_hd_idx  = r_q_idx[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !(i_hd_pop && o_hd_v)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_wr && i_hd_pop && o_hd_v) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_hd_pop && o_hd_v) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q_item[r_wp] <= w_item;
            r_q_idx[r_wp]  <= w_idx;
        end
    end

endmodule

// ===== design/cpml_back.sv =====
`include "cpml_point_update_macros.svh"

module cpml_back
    import cpml_pkg::*;
#(
    parameter int POINT_SLOTS = DEF_POINT_SLOTS,
    parameter int AW          = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_isp,
    input  logic              i_hd_v,
    input  t_item             i_hd_item,
    input  logic [AW-1:0]     i_hd_idx,
    output logic              o_hd_pop,
    output logic              o_clearing,
    output logic              empty,
    input  logic              pop,
    output logic [SLOT_W-1:0] o_out_slot,
    output logic [31:0]       o_accum_out,
    output logic              o_saturated
);

    logic w_adv;
    logic w_pop;

    logic          r_clearing;
    logic [AW-1:0] r_clr_idx;

    logic signed [31:0] r_mem_a [POINT_SLOTS];
    logic signed [31:0] r_mem_b [POINT_SLOTS];
    logic signed [31:0] r_rd_a;
    logic signed [31:0] r_rd_b;

    // Stage 1: stored terms arrive, differences are scaled.
    logic               r_s1_v;
    t_item              r_s1_item;
    logic [AW-1:0]      r_s1_idx;
    logic               r_s1_fw;
    logic signed [31:0] r_s1_fa;
    logic signed [31:0] r_s1_fb;
    logic signed [31:0] w_s1_prev_a;
    logic signed [31:0] w_s1_prev_b;
    logic signed [65:0] w_s1_pa;
    logic signed [65:0] w_s1_pb;

    // Stage 2: curl saturation.
    logic               r_s2_v;
    t_item              r_s2_item;
    logic [AW-1:0]      r_s2_idx;
    logic signed [31:0] r_s2_prev_a;
    logic signed [31:0] r_s2_prev_b;
    logic signed [65:0] r_s2_pa;
    logic signed [65:0] r_s2_pb;
    logic signed [31:0] w_s2_curl_a;
    logic signed [31:0] w_s2_curl_b;

    // Stage 3: gain and stretch products.
    logic               r_s3_v;
    t_item              r_s3_item;
    logic [AW-1:0]      r_s3_idx;
    logic signed [31:0] r_s3_prev_a;
    logic signed [31:0] r_s3_prev_b;
    logic signed [31:0] r_s3_curl_a;
    logic signed [31:0] r_s3_curl_b;
    logic signed [63:0] w_s3_g_a;
    logic signed [63:0] w_s3_g_b;
    logic signed [63:0] w_s3_k_a;
    logic signed [63:0] w_s3_k_b;

    // Stage 4: recursion of the stored terms, written back.
    logic               r_s4_v;
    logic [SLOT_W-1:0]  r_s4_slot;
    logic [AW-1:0]      r_s4_idx;
    logic signed [31:0] r_s4_accum;
    logic signed [31:0] r_s4_dec_a;
    logic signed [31:0] r_s4_dec_b;
    logic signed [31:0] r_s4_prev_a;
    logic signed [31:0] r_s4_prev_b;
    logic signed [33:0] r_s4_g_a;
    logic signed [33:0] r_s4_g_b;
    logic signed [33:0] r_s4_k_a;
    logic signed [33:0] r_s4_k_b;
    logic signed [63:0] w_s4_d_a;
    logic signed [63:0] w_s4_d_b;
    logic signed [34:0] w_s4_sum_a;
    logic signed [34:0] w_s4_sum_b;
    logic signed [31:0] w_phi_a;
    logic signed [31:0] w_phi_b;

    // Stage 5: accumulator sum and saturation.
    logic               r_s5_v;
    logic [SLOT_W-1:0]  r_s5_slot;
    logic signed [31:0] r_s5_accum;
    logic signed [31:0] r_s5_phi_a;
    logic signed [31:0] r_s5_phi_b;
    logic signed [33:0] r_s5_k_a;
    logic signed [33:0] r_s5_k_b;
    logic signed [36:0] w_s5_sum;
    logic signed [31:0] w_s5_acc;
    logic               w_s5_clip;

    logic [SLOT_W-1:0] r_oq_slot [2];
    logic [31:0]       r_oq_acc  [2];
    logic              r_oq_sat  [2];
    logic              r_oq_wp;
    logic              r_oq_rp;
    logic [1:0]        r_oq_cnt;
    logic [1:0]        n_oq_cnt;
    logic              w_oq_wr;
    logic              w_oq_rd;

    assign w_adv      = (r_oq_cnt != 2'd2);
    assign w_pop      = w_adv && i_hd_v && !r_clearing;
    assign o_hd_pop   = w_pop;
    assign o_clearing = r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + AW'(1);
            if (r_clr_idx == AW'(POINT_SLOTS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem_a[r_clr_idx] <= '0;
            r_mem_b[r_clr_idx] <= '0;
        end else if (w_adv && r_s4_v) begin
            r_mem_a[r_s4_idx] <= w_phi_a;
            r_mem_b[r_s4_idx] <= w_phi_b;
        end
        if (w_pop) begin
            r_rd_a <= r_mem_a[i_hd_idx];
            r_rd_b <= r_mem_b[i_hd_idx];
        end
    end

    assign w_s1_prev_a = r_s1_fw ? r_s1_fa : r_rd_a;
    assign w_s1_prev_b = r_s1_fw ? r_s1_fb : r_rd_b;
    assign w_s1_pa     = r_s1_item.diff_a * $signed({1'b0, i_isp});
    assign w_s1_pb     = r_s1_item.diff_b * $signed({1'b0, i_isp});

    assign w_s2_curl_a = f_sat32({{14{r_s2_pa[65]}}, r_s2_pa[65:16]});
    assign w_s2_curl_b = f_sat32({{14{r_s2_pb[65]}}, r_s2_pb[65:16]});

    assign w_s3_g_a = r_s3_item.gain_a * r_s3_curl_a;
    assign w_s3_g_b = r_s3_item.gain_b * r_s3_curl_b;
    assign w_s3_k_a = r_s3_item.kinv_a * r_s3_curl_a;
    assign w_s3_k_b = r_s3_item.kinv_b * r_s3_curl_b;

    assign w_s4_d_a   = r_s4_dec_a * r_s4_prev_a;
    assign w_s4_d_b   = r_s4_dec_b * r_s4_prev_b;
    assign w_s4_sum_a = {w_s4_d_a[63], w_s4_d_a[63:30]} + {r_s4_g_a[33], r_s4_g_a};
    assign w_s4_sum_b = {w_s4_d_b[63], w_s4_d_b[63:30]} + {r_s4_g_b[33], r_s4_g_b};
    assign w_phi_a    = f_sat32({{29{w_s4_sum_a[34]}}, w_s4_sum_a});
    assign w_phi_b    = f_sat32({{29{w_s4_sum_b[34]}}, w_s4_sum_b});

    assign w_s5_sum = {{5{r_s5_accum[31]}}, r_s5_accum}
                    + {{5{r_s5_phi_a[31]}}, r_s5_phi_a}
                    - {{5{r_s5_phi_b[31]}}, r_s5_phi_b}
                    + {{3{r_s5_k_a[33]}}, r_s5_k_a}
                    - {{3{r_s5_k_b[33]}}, r_s5_k_b};
    assign w_s5_acc  = f_sat32({{27{w_s5_sum[36]}}, w_s5_sum});
    assign w_s5_clip = ({{27{w_s5_sum[36]}}, w_s5_sum} != {{32{w_s5_acc[31]}}, w_s5_acc});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= w_pop;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
        end
    end

    // Items behind the write stage take the new terms of an older item of the same slot.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_item <= i_hd_item;
            r_s1_idx  <= i_hd_idx;
            r_s1_fw   <= r_s4_v && (r_s4_idx == i_hd_idx);
            r_s1_fa   <= w_phi_a;
            r_s1_fb   <= w_phi_b;

            r_s2_item   <= r_s1_item;
            r_s2_idx    <= r_s1_idx;
            r_s2_pa     <= w_s1_pa;
            r_s2_pb     <= w_s1_pb;
            r_s2_prev_a <= (r_s4_v && r_s4_idx == r_s1_idx) ? w_phi_a : w_s1_prev_a;
            r_s2_prev_b <= (r_s4_v && r_s4_idx == r_s1_idx) ? w_phi_b : w_s1_prev_b;

            r_s3_item   <= r_s2_item;
            r_s3_idx    <= r_s2_idx;
            r_s3_curl_a <= w_s2_curl_a;
            r_s3_curl_b <= w_s2_curl_b;
            r_s3_prev_a <= (r_s4_v && r_s4_idx == r_s2_idx) ? w_phi_a : r_s2_prev_a;
            r_s3_prev_b <= (r_s4_v && r_s4_idx == r_s2_idx) ? w_phi_b : r_s2_prev_b;

            r_s4_slot   <= r_s3_item.slot;
            r_s4_idx    <= r_s3_idx;
            r_s4_accum  <= r_s3_item.accum;
            r_s4_dec_a  <= r_s3_item.decay_a;
            r_s4_dec_b  <= r_s3_item.decay_b;
            r_s4_g_a    <= w_s3_g_a[63:30];
            r_s4_g_b    <= w_s3_g_b[63:30];
            r_s4_k_a    <= w_s3_k_a[63:30];
            r_s4_k_b    <= w_s3_k_b[63:30];
            r_s4_prev_a <= (r_s4_v && r_s4_idx == r_s3_idx) ? w_phi_a : r_s3_prev_a;
            r_s4_prev_b <= (r_s4_v && r_s4_idx == r_s3_idx) ? w_phi_b : r_s3_prev_b;

            r_s5_slot  <= r_s4_slot;
            r_s5_accum <= r_s4_accum;
            r_s5_phi_a <= w_phi_a;
            r_s5_phi_b <= w_phi_b;
            r_s5_k_a   <= r_s4_k_a;
            r_s5_k_b   <= r_s4_k_b;
        end
    end

    assign w_oq_wr     = w_adv && r_s5_v;
    assign w_oq_rd     = pop && (r_oq_cnt != 2'd0);
    assign empty       = (r_oq_cnt == 2'd0);
    assign o_out_slot  = r_oq_slot[r_oq_rp];
    assign o_accum_out = r_oq_acc[r_oq_rp];
    assign o_saturated = r_oq_sat[r_oq_rp];

    always_comb begin
        n_oq_cnt = r_oq_cnt;
        if (w_oq_wr && !w_oq_rd) begin
            n_oq_cnt = r_oq_cnt + 2'd1;
        end else if (!w_oq_wr && w_oq_rd) begin
            n_oq_cnt = r_oq_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            r_oq_cnt <= n_oq_cnt;
            if (w_oq_wr) begin
                r_oq_wp <= ~r_oq_wp;
            end
            if (w_oq_rd) begin
                r_oq_rp <= ~r_oq_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oq_wr) begin
            r_oq_slot[r_oq_wp] <= r_s5_slot;
            r_oq_acc[r_oq_wp]  <= w_s5_acc;
            r_oq_sat[r_oq_wp]  <= w_s5_clip;
        end
    end

    `CPML_ASSERT_NOW(a_oq_bound, 1'b1, r_oq_cnt != 2'd3)
    `CPML_ASSERT_NOW(a_no_pop_clear, r_clearing, !w_pop && !r_s4_v)
    `CPML_ASSERT_NEXT(a_result_queued, w_oq_wr && !w_oq_rd, r_oq_cnt != 2'd0)
    `CPML_ASSERT_NOW(a_clear_end, $fell(r_clearing), $past(r_clr_idx) == AW'(POINT_SLOTS - 1))

endmodule

// ===== test/cpml_point_update_tb.sv =====
`timescale 1ns / 100ps

module cpml_point_update_tb;
    import cpml_pkg::*;

    localparam int  SLOTS      = DEF_POINT_SLOTS;
    localparam int  RAND_ITEMS = 250;
    localparam int  CYCLE_CAP  = 2000000;
    localparam int  DRAIN_WAIT = 20;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic signed [31:0] fwd_a;
        logic signed [31:0] back_a;
        logic signed [31:0] fwd_b;
        logic signed [31:0] back_b;
        logic signed [31:0] accum;
        logic signed [31:0] decay_a;
        logic signed [31:0] gain_a;
        logic signed [31:0] kinv_a;
        logic signed [31:0] decay_b;
        logic signed [31:0] gain_b;
        logic signed [31:0] kinv_b;
    } point_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic signed [31:0] accum;
        logic               sat;
    } update_t;

    typedef struct packed {
        point_t  pt;
        logic    typed;
        update_t want;
    } row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               push;
    logic               full;
    point_t             word_in;
    logic               empty;
    logic               pop;
    logic [SLOT_W-1:0]  o_out_slot;
    logic [31:0]        o_accum_out;
    logic               o_saturated;

    logic [31:0] spacing_model;
    int          term_a_model [SLOTS];
    int          term_b_model [SLOTS];
    update_t     pending_updates [$];
    row_t        directed_rows [$];
    int          errors = 0;
    int          cycle_count = 0;
    logic        calm = 1'b0;

    cpml_point_update uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full),
        .i_slot(word_in.slot),
        .i_field_fwd_a(word_in.fwd_a), .i_field_back_a(word_in.back_a),
        .i_field_fwd_b(word_in.fwd_b), .i_field_back_b(word_in.back_b),
        .i_accum_in(word_in.accum),
        .i_decay_a(word_in.decay_a), .i_gain_a(word_in.gain_a),
        .i_stretch_inv_a(word_in.kinv_a),
        .i_decay_b(word_in.decay_b), .i_gain_b(word_in.gain_b),
        .i_stretch_inv_b(word_in.kinv_b),
        .empty(empty), .pop(pop),
        .o_out_slot(o_out_slot), .o_accum_out(o_accum_out), .o_saturated(o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clip32(input longint x, output logic hit);
        hit = 1'b0;
        if (x > longint'(Q_MAX)) begin
            hit = 1'b1;
            return longint'(Q_MAX);
        end
        if (x < longint'(Q_MIN)) begin
            hit = 1'b1;
            return longint'(Q_MIN);
        end
        return x;
    endfunction

    function automatic longint scaled_curl(input logic signed [31:0] fwd,
                                           input logic signed [31:0] back);
        longint d;
        logic   unused;
        d = longint'(fwd) - longint'(back);
        return clip32(d * longint'(spacing_model[31:16])
                      + ((d * longint'(spacing_model[15:0])) >>> 16), unused);
    endfunction

    function automatic longint conv_step(input logic signed [31:0] decay, input longint prev,
                                         input logic signed [31:0] gain, input longint curl);
        logic unused;
        return clip32(((longint'(decay) * prev) >>> 30)
                      + ((longint'(gain) * curl) >>> 30), unused);
    endfunction

    function automatic update_t cpml_update(input point_t p);
        update_t r;
        longint  ca, cb, pa, pb, total;
        int      idx;
        idx = int'(p.slot) % SLOTS;
        ca = scaled_curl(p.fwd_a, p.back_a);
        cb = scaled_curl(p.fwd_b, p.back_b);
        pa = conv_step(p.decay_a, longint'(term_a_model[idx]), p.gain_a, ca);
        pb = conv_step(p.decay_b, longint'(term_b_model[idx]), p.gain_b, cb);
        term_a_model[idx] = int'(pa);
        term_b_model[idx] = int'(pb);
        total = longint'(p.accum) + pa - pb
              + ((ca * longint'(p.kinv_a)) >>> 30) - ((cb * longint'(p.kinv_b)) >>> 30);
        r.slot  = p.slot;
        r.accum = 32'(clip32(total, r.sat));
        return r;
    endfunction

    function automatic void append_row(input row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [31:0] pick_coef();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h4000_0000);
            2: return -$signed({1'b0, 31'($urandom_range(0, 32'h4000_0000))});
            default: return ONE_Q30 - 32'($urandom_range(0, 32'h0100_0000));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_field();
        if ($urandom_range(0, 2) == 0) begin
            return $urandom;
        end
        return $signed(32'($urandom_range(0, 32'h0400_0000))) - 32'sh0200_0000;
    endfunction

    function automatic point_t random_point();
        point_t p;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: p.slot = SLOT_W'($urandom_range(0, 7));
            4: p.slot = SLOT_W'($urandom_range(SLOTS - 4, SLOTS - 1));
            default: p.slot = SLOT_W'($urandom);
        endcase
        p.fwd_a   = pick_field();
        p.back_a  = pick_field();
        p.fwd_b   = pick_field();
        p.back_b  = pick_field();
        p.accum   = pick_field();
        p.decay_a = pick_coef();
        p.gain_a  = pick_coef();
        p.kinv_a  = pick_coef();
        p.decay_b = pick_coef();
        p.gain_b  = pick_coef();
        p.kinv_b  = pick_coef();
        return p;
    endfunction

    task automatic send_word(input point_t p, input logic typed, input update_t want);
        update_t got;
        push    <= 1'b1;
        word_in <= p;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        got = cpml_update(p);
        pending_updates.insert(pending_updates.size(), typed ? want : got);
        repeat (pick_gap()) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_spacing(input logic [31:0] value);
        push <= 1'b0;
        while (pending_updates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ISP;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        spacing_model = value;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 400 == 0) begin
            calm <= ($urandom_range(0, 2) == 0);
        end
        if (cycle_count > CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int stall;
        stall = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                pop <= 1'b0;
            end else begin
                pop   <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        update_t exp_word;
        if (i_rst_n && pop && !empty) begin
            if (pending_updates.size() == 0) begin
                $error("result word with nothing expected: slot %0d", o_out_slot);
                errors++;
            end else begin
                exp_word = pending_updates.pop_front();
                if (o_out_slot !== exp_word.slot) begin
                    $error("out_slot: expected %0d, got %0d", exp_word.slot, o_out_slot);
                    errors++;
                end
                if (o_accum_out !== exp_word.accum) begin
                    $error("accum_out: expected %0d, got %0d", exp_word.accum,
                           $signed(o_accum_out));
                    errors++;
                end
                if (o_saturated !== exp_word.sat) begin
                    $error("saturated: expected %0b, got %0b", exp_word.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        point_t        z;
        update_t       none;
        logic [31:0]   spacings [$];
        int            waited;
        z    = '0;
        none = '0;
        spacing_model = ISP_RESET;
        foreach (term_a_model[k]) begin
            term_a_model[k] = 0;
            term_b_model[k] = 0;
        end
        i_rst_n <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ISP;
        pwdata  <= '0;
        push    <= 1'b0;
        word_in <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        append_row('{z, 1'b1, '{12'd0, 32'sd0, 1'b0}});
        append_row('{'{12'd1, 0, 0, 0, 0, Q_MAX, 0, 0, 0, 0, 0, 0},
                     1'b1, '{12'd1, Q_MAX, 1'b0}});
        append_row('{'{12'd2, 0, 0, 0, 0, Q_MIN, 0, 0, 0, 0, 0, 0},
                     1'b1, '{12'd2, Q_MIN, 1'b0}});
        append_row('{'{12'd3, Q_MAX, Q_MIN, 0, 0, 0, 0, 0, Q_MAX, 0, 0, 0},
                     1'b1, '{12'd3, Q_MAX, 1'b1}});
        append_row('{'{12'd4, Q_MIN, Q_MAX, 0, 0, 0, 0, 0, Q_MAX, 0, 0, 0},
                     1'b1, '{12'd4, Q_MIN, 1'b1}});
        append_row('{'{12'd4095, 0, 0, Q_MAX, Q_MIN, 0, 0, 0, 0, 0, 0, Q_MAX},
                     1'b1, '{12'd4095, Q_MIN, 1'b1}});
        for (int n = 0; n < 4; n++) begin
            append_row('{'{12'd5, 32'sh0100_0000, 0, 0, 32'sh0080_0000, 0,
                           ONE_Q30, ONE_Q30, ONE_Q30, ONE_Q30, ONE_Q30,
                           ONE_Q30}, 1'b0, none});
        end
        for (int n = 0; n < 3; n++) begin
            append_row('{'{12'd6, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX,
                           Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX},
                         1'b0, none});
        end
        append_row('{'{12'd4095, -32'sd1, 32'sd1, 32'sd1, -32'sd1, -32'sd1,
                       Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX}, 1'b0, none});
        append_row('{'{12'd7, 32'sh0000_0001, 0, 0, 32'sh0000_0001, Q_MAX - 2,
                       0, ONE_Q30, ONE_Q30, 0, ONE_Q30, Q_MIN}, 1'b0, none});
        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].pt, directed_rows[k].typed, directed_rows[k].want);
        end

        spacings = '{ISP_RESET, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_8000,
                     $urandom, ISP_RESET};
        foreach (spacings[k]) begin
            if (k != 0) begin
                write_spacing(spacings[k]);
            end
            repeat (RAND_ITEMS - 50 * (k % 2)) begin
                send_word(random_point(), 1'b0, none);
            end
        end
        push <= 1'b0;

        waited = 0;
        while (pending_updates.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0 && pending_updates.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/cpml_pkg.sv
design/cpml_front.sv
design/cpml_back.sv
design/cpml_point_update.sv
test/cpml_point_update_tb.sv
